/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a clocked property; the check is suspended while rst is high.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");

// Checks that a condition never holds at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

/* rtl/ptpc_pkg.sv */
package ptpc_pkg;

   // Fixed datapath widths.
   localparam int MUL_W  = 32;            // serial multiplier operand width
   localparam int PROD_W = 2 * MUL_W;     // product width
   localparam int DIVD_W = 64;            // divider dividend width
   localparam int DIVR_W = 33;            // divider divisor width
   localparam int CYC_W  = 35;            // 2^64 / 10^9 stays below 2^35
   localparam int CSR_IDX_W = 1;

   // Parameter defaults for the top level.
   localparam int PERIOD_BITS_DEF  = 16;
   localparam int MAX_DIV_CODE_DEF = 7;

   // Constants.
   localparam logic [DIVR_W-1:0] NS_PER_SEC  = 33'd1000000000;
   localparam logic [DIVR_W-1:0] PCT_DIVISOR = 33'd100;
   localparam logic [6:0]        PCT_FULL    = 7'd100;
   localparam logic [63:0]       PRESCALE_LIMIT = 64'd256;
   localparam logic [15:0]       FIELD16_MAX = 16'hffff;

   localparam logic [31:0] CLK_HZ_RESET = 32'd200000000;
   localparam logic [31:0] PERIOD_RESET = 32'd50000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CLK_HZ = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_PCT = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   // Handshake status of a serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CYC_MUL,
      ST_CYC_DIV,
      ST_FIT,
      ST_PRE_DIV,
      ST_PRD_DIV,
      ST_DNS_MUL,
      ST_DNS_DIV,
      ST_DCY_MUL,
      ST_DCY_DIV,
      ST_DUTY_DIV
   } state_type;

endpackage

/* rtl/ptpc_mul.sv */
module ptpc_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [ptpc_pkg::MUL_W-1:0]      mcand,
   input  logic [ptpc_pkg::MUL_W-1:0]      mplier,
   output logic [ptpc_pkg::PROD_W-1:0]     prod,
   output ptpc_pkg::unit_status_type       st
);
   import ptpc_pkg::*;

   localparam int CNT_W = $clog2(MUL_W + 1);

   logic [MUL_W-1:0]  mcand_ff, mcand_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [MUL_W:0]    sum;

   // Shift-and-add, one multiplier bit per cycle: the low half holds the
   // remaining multiplier bits and the high half the running sum.
   always_comb begin
      sum = {1'b0, prod_ff[PROD_W-1:MUL_W]}
            + (prod_ff[0] ? {1'b0, mcand_ff} : {(MUL_W + 1){1'b0}});
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (go) begin
         mcand_in = mcand;
         prod_in  = {{MUL_W{1'b0}}, mplier};
         cnt_in   = CNT_W'(MUL_W);
      end else if (cnt_ff != '0) begin
         prod_in = {sum, prod_ff[MUL_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign prod    = prod_ff;
   assign st.busy = (cnt_ff != '0);
   assign st.done = done_ff;

endmodule

/* rtl/ptpc_div.sv */
module ptpc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [ptpc_pkg::DIVD_W-1:0]     dividend,
   input  logic [ptpc_pkg::DIVR_W-1:0]     divisor,
   output logic [ptpc_pkg::DIVD_W-1:0]     quo,
   output logic [ptpc_pkg::DIVR_W-1:0]     rem,
   output ptpc_pkg::unit_status_type       st
);
   import ptpc_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0] q_ff, q_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dsor_ff, dsor_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   shifted;
   logic [DIVR_W:0]   diff;
   logic              fits;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // of the top of q_ff while quotient bits shift in at the bottom.
   always_comb begin
      shifted = {rem_ff, q_ff[DIVD_W-1]};
      diff    = shifted - {1'b0, dsor_ff};
      fits    = (shifted >= {1'b0, dsor_ff});
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (go) begin
         q_in    = dividend;
         rem_in  = '0;
         dsor_in = divisor;
         cnt_in  = CNT_W'(DIVD_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
         q_in    = {q_ff[DIVD_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign quo     = q_ff;
   assign rem     = rem_ff;
   assign st.busy = (cnt_ff != '0);
   assign st.done = done_ff;

endmodule

/* rtl/pwm_timing_param_calc.sv */
// PWM timing calculator. Pulse req_start with a brightness percent while busy
// is low; the block then derives the divider code, prescale, period count and
// duty count from the configured source clock (register 0, hertz) and PWM
// period (register 1, nanoseconds). Exactly one result comes back per item, on
// the rsp_ ports for a single cycle marked by rsp_valid; it cannot be held
// off, so the receiver must take it in that cycle. For a percent of 100 or
// less the work is six passes through a radix-2 divider with 64 quotient
// bits and three passes through a bit-serial 32-bit multiplier, plus a
// search for the divider code (with the default MAX_DIV_CODE of 7). When
// the period is under one divided clock the period division is skipped. A
// percent above 100 is answered on the next cycle with status 1. For an
// in-range percent busy stays high from acceptance until the cycle the
// result appears, and the register port only takes writes while busy is low.
`include "assert_macros.svh"

module pwm_timing_param_calc #(
   parameter int PERIOD_BITS  = ptpc_pkg::PERIOD_BITS_DEF,
   parameter int MAX_DIV_CODE = ptpc_pkg::MAX_DIV_CODE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Item request.
   input  logic                               req_start,
   output logic                               busy,
   input  logic [6:0]                         req_percent,
   // Result.
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_div_code,
   output logic [7:0]                         rsp_prescale_code,
   output logic [15:0]                        rsp_period_code,
   output logic [15:0]                        rsp_duty_code,
   output logic                               rsp_duty_zero,
   output logic [1:0]                         rsp_status,
   // Register writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);
   import ptpc_pkg::*;

   localparam int DIV_W = (MAX_DIV_CODE < 1) ? 1 : $clog2(MAX_DIV_CODE + 1);
   localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(MAX_DIV_CODE);
   // Largest period count and largest scaled period that prescale 256 covers.
   localparam logic [63:0] PMAX  = (64'd1 << PERIOD_BITS) - 64'd1;
   localparam logic [63:0] LIMIT = PMAX << 8;

   state_type state_ff, state_in;

   logic [31:0]      clk_hz_ff, clk_hz_in;
   logic [31:0]      period_ff, period_in;
   logic [6:0]       pct_ff, pct_in;
   logic [CYC_W-1:0] cycles_ff, cycles_in;
   logic [DIV_W-1:0] divc_ff, divc_in;
   logic [8:0]       pre_ff, pre_in;
   logic [15:0]      prd_ff, prd_in;
   logic [31:0]      dns_ff, dns_in;
   logic [CYC_W-1:0] dcyc_ff, dcyc_in;
   logic [1:0]       status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_div_code_ff, rsp_div_code_in;
   logic [7:0]       rsp_prescale_ff, rsp_prescale_in;
   logic [15:0]      rsp_period_ff, rsp_period_in;
   logic [15:0]      rsp_duty_ff, rsp_duty_in;
   logic             rsp_zero_ff, rsp_zero_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   // Serial unit hookup.
   logic              mul_go;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_prod;
   unit_status_type   mul_st;
   logic              div_go;
   logic [DIVD_W-1:0] div_n;
   logic [DIVR_W-1:0] div_d;
   logic [DIVD_W-1:0] div_quo;
   logic [DIVR_W-1:0] div_rem;
   unit_status_type   div_st;

   // Datapath helpers.
   logic [5:0]        shamt;
   logic [63:0]       scaled;
   logic [63:0]       pre_raw, pre_clip;
   logic [63:0]       prd_raw, prd_clip;
   logic [15:0]       divc_wide;
   logic [8:0]        pre_m1;

   ptpc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .go     (mul_go),
      .mcand  (mul_a),
      .mplier (mul_b),
      .prod   (mul_prod),
      .st     (mul_st)
   );

   ptpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_n),
      .divisor  (div_d),
      .quo      (div_quo),
      .rem      (div_rem),
      .st       (div_st)
   );

   // The clock is divided by two to the power (code + 1).
   assign shamt     = 6'(divc_ff) + 6'd1;
   assign scaled    = 64'(cycles_ff) >> shamt;
   assign divc_wide = 16'(divc_ff);
   assign pre_m1    = pre_ff - 9'd1;

   // Prescale is the ceiling of scaled / PMAX, clamped to 256.
   assign pre_raw  = div_quo + 64'(div_rem != '0);
   assign pre_clip = (pre_raw > PRESCALE_LIMIT) ? PRESCALE_LIMIT : pre_raw;
   // Period count is scaled / prescale minus one, floored at zero and capped at PMAX.
   assign prd_raw  = (div_quo == 64'd0) ? 64'd0 : div_quo - 64'd1;
   assign prd_clip = (prd_raw > PMAX) ? PMAX : prd_raw;

   always_comb begin
      state_in  = state_ff;
      clk_hz_in = clk_hz_ff;
      period_in = period_ff;
      pct_in    = pct_ff;
      cycles_in = cycles_ff;
      divc_in   = divc_ff;
      pre_in    = pre_ff;
      prd_in    = prd_ff;
      dns_in    = dns_ff;
      dcyc_in   = dcyc_ff;
      status_in = status_ff;

      rsp_valid_in    = 1'b0;
      rsp_div_code_in = rsp_div_code_ff;
      rsp_prescale_in = rsp_prescale_ff;
      rsp_period_in   = rsp_period_ff;
      rsp_duty_in     = rsp_duty_ff;
      rsp_zero_in     = rsp_zero_ff;
      rsp_status_in   = rsp_status_ff;

      mul_go = 1'b0;
      mul_a  = clk_hz_ff;
      mul_b  = period_ff;
      div_go = 1'b0;
      div_n  = '0;
      div_d  = NS_PER_SEC;

      // Register writes are only taken while no item is in flight.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLK_HZ: clk_hz_in = csr_wdata;
            CSR_PERIOD: period_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               pct_in    = req_percent;
               divc_in   = '0;
               status_in = STATUS_OK;
               if (req_percent > PCT_FULL) begin
                  // Rejected request: every other field reads zero.
                  rsp_valid_in    = 1'b1;
                  rsp_div_code_in = 3'd0;
                  rsp_prescale_in = 8'd0;
                  rsp_period_in   = 16'd0;
                  rsp_duty_in     = 16'd0;
                  rsp_zero_in     = 1'b0;
                  rsp_status_in   = STATUS_BAD_PCT;
               end else begin
                  // Source clock cycles in one period: clock * period / 10^9.
                  mul_go   = 1'b1;
                  state_in = ST_CYC_MUL;
               end
            end
         end
         ST_CYC_MUL: begin
            if (mul_st.done) begin
               div_go   = 1'b1;
               div_n    = mul_prod;
               div_d    = NS_PER_SEC;
               state_in = ST_CYC_DIV;
            end
         end
         ST_CYC_DIV: begin
            if (div_st.done) begin
               cycles_in = div_quo[CYC_W-1:0];
               state_in  = ST_FIT;
            end
         end
         ST_FIT: begin
            // Try one divider code per cycle, smallest first. If none fits,
            // the largest code is kept and the item is flagged out of range.
            if (scaled <= LIMIT || divc_ff == DIV_MAX) begin
               if (scaled > LIMIT) begin
                  status_in = STATUS_RANGE;
               end
               div_go   = 1'b1;
               div_n    = scaled;
               div_d    = DIVR_W'(PMAX);
               state_in = ST_PRE_DIV;
            end else begin
               divc_in = divc_ff + DIV_W'(1);
            end
         end
         ST_PRE_DIV: begin
            if (div_st.done) begin
               if (pre_raw == 64'd0) begin
                  // Period under one divided clock: prescale 1, count zero.
                  pre_in    = 9'd1;
                  prd_in    = 16'd0;
                  status_in = STATUS_RANGE;
                  mul_go    = 1'b1;
                  mul_a     = period_ff;
                  mul_b     = 32'(pct_ff);
                  state_in  = ST_DNS_MUL;
               end else begin
                  pre_in   = pre_clip[8:0];
                  div_go   = 1'b1;
                  div_n    = scaled;
                  div_d    = DIVR_W'(pre_clip[8:0]);
                  state_in = ST_PRD_DIV;
               end
            end
         end
         ST_PRD_DIV: begin
            if (div_st.done) begin
               prd_in   = prd_clip[15:0];
               mul_go   = 1'b1;
               mul_a    = period_ff;
               mul_b    = 32'(pct_ff);
               state_in = ST_DNS_MUL;
            end
         end
         ST_DNS_MUL: begin
            if (mul_st.done) begin
               div_go   = 1'b1;
               div_n    = mul_prod;
               div_d    = PCT_DIVISOR;
               state_in = ST_DNS_DIV;
            end
         end
         ST_DNS_DIV: begin
            if (div_st.done) begin
               // Duty time never exceeds the period, so it fits 32 bits.
               dns_in   = div_quo[31:0];
               mul_go   = 1'b1;
               mul_a    = clk_hz_ff;
               mul_b    = div_quo[31:0];
               state_in = ST_DCY_MUL;
            end
         end
         ST_DCY_MUL: begin
            if (mul_st.done) begin
               div_go   = 1'b1;
               div_n    = mul_prod;
               div_d    = NS_PER_SEC;
               state_in = ST_DCY_DIV;
            end
         end
         ST_DCY_DIV: begin
            if (div_st.done) begin
               dcyc_in  = div_quo[CYC_W-1:0];
               div_go   = 1'b1;
               div_n    = 64'(div_quo[CYC_W-1:0]) >> shamt;
               div_d    = DIVR_W'(pre_ff);
               state_in = ST_DUTY_DIV;
            end
         end
         ST_DUTY_DIV: begin
            if (div_st.done) begin
               rsp_valid_in    = 1'b1;
               rsp_div_code_in = divc_wide[2:0];
               rsp_prescale_in = pre_m1[7:0];
               rsp_period_in   = prd_ff;
               rsp_duty_in     = (div_quo > 64'(FIELD16_MAX)) ? FIELD16_MAX
                                                             : div_quo[15:0];
               rsp_zero_in     = (div_quo == 64'd0);
               rsp_status_in   = status_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_hz_ff    <= CLK_HZ_RESET;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pct_ff          <= pct_in;
      cycles_ff       <= cycles_in;
      divc_ff         <= divc_in;
      pre_ff          <= pre_in;
      prd_ff          <= prd_in;
      dns_ff          <= dns_in;
      dcyc_ff         <= dcyc_in;
      status_ff       <= status_in;
      rsp_div_code_ff <= rsp_div_code_in;
      rsp_prescale_ff <= rsp_prescale_in;
      rsp_period_ff   <= rsp_period_in;
      rsp_duty_ff     <= rsp_duty_in;
      rsp_zero_ff     <= rsp_zero_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_div_code      = rsp_div_code_ff;
   assign rsp_prescale_code = rsp_prescale_ff;
   assign rsp_period_code   = rsp_period_ff;
   assign rsp_duty_code     = rsp_duty_ff;
   assign rsp_duty_zero     = rsp_zero_ff;
   assign rsp_status        = rsp_status_ff;

   // A result only appears once the sequencer is back to idle.
   `ASSERT_NEVER(a_rsp_idle, clock, reset, rsp_valid && busy)
   // An accepted in-range request starts the sequence.
   `ASSERT_PROP(a_accept_busy, clock, reset,
      req_start && !busy && (req_percent <= PCT_FULL) |=> busy)
   // The sequencer never runs the multiplier and the divider together.
   `ASSERT_NEVER(a_units_exclusive, clock, reset, mul_st.busy && div_st.busy)
   // A rejected request reports a zero duty count, a clear zero duty flag and a zero prescale code.
   `ASSERT_PROP(a_bad_pct_zero, clock, reset,
      rsp_valid && (rsp_status == STATUS_BAD_PCT) |-> (rsp_duty_code == 16'd0)
      && !rsp_duty_zero && (rsp_prescale_code == 8'd0))
   // A zero duty flag always comes with a zero duty count.
   `ASSERT_PROP(a_zero_flag, clock, reset,
      rsp_valid && rsp_duty_zero |-> (rsp_duty_code == 16'd0))

endmodule

/* tb/tb.sv */
// Testbench for the PWM timing calculator.
//
// Each item is one brightness percent. Against the current source clock and
// period registers, the block returns one result: the divider code, the
// prescale code, the period count, the duty count, a zero duty flag and a
// status. A model inside this bench works out every result from its own copy
// of the two registers. The monitor compares each result with the oldest
// outstanding prediction.
module tb;
   import ptpc_pkg::*;

   // Kinds of step that the stimulus plan can hold.
   typedef enum logic [1:0] {
      STEP_ITEM,
      STEP_WRITE,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type         kind;
      logic [6:0]            percent;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           data;
   } plan_step_type;

   // One predicted result, with the same field widths as the rsp_ ports.
   typedef struct {
      logic [2:0]  div_code;
      logic [7:0]  prescale_code;
      logic [15:0] period_code;
      logic [15:0] duty_code;
      logic        duty_zero;
      logic [1:0]  status;
   } pwm_timing_type;

   // The watchdog ends the run after this many cycles in which nothing moves.
   // It is far longer than one item and the longest sender gap together, so
   // this leaves a wide margin.
   localparam int STALL_LIMIT = 6000;
   // Quiet time at the end. It is longer than one full item.
   localparam int DRAIN_TAIL = 700;
   localparam int ITEM_TARGET = 1950;

   logic        clock;
   logic        reset;
   logic        req_start = 1'b0;
   logic        busy;
   logic [6:0]  req_percent = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_div_code;
   logic [7:0]  rsp_prescale_code;
   logic [15:0] rsp_period_code;
   logic [15:0] rsp_duty_code;
   logic        rsp_duty_zero;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pwm_timing_param_calc DUT (
      .clock             (clock),
      .reset             (reset),
      .req_start         (req_start),
      .busy              (busy),
      .req_percent       (req_percent),
      .rsp_valid         (rsp_valid),
      .rsp_div_code      (rsp_div_code),
      .rsp_prescale_code (rsp_prescale_code),
      .rsp_period_code   (rsp_period_code),
      .rsp_duty_code     (rsp_duty_code),
      .rsp_duty_zero     (rsp_duty_zero),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // The stimulus plan and the store of predicted results.
   plan_step_type  request_plan[$];
   pwm_timing_type expected_timing[$];

   // The bench's copy of the two registers. The driver updates it when a
   // write is taken, so every prediction sees the settings in force.
   logic [63:0] model_clk_hz    = 64'(CLK_HZ_RESET);
   logic [63:0] model_period_ns = 64'(PERIOD_RESET);

   // Counters. n_issued belongs to the driver. n_results is updated by the
   // monitor with nonblocking assignments only, so the driver always reads
   // the value from before the current edge.
   int unsigned n_issued = 0;
   int unsigned n_results = 0;
   int unsigned n_errors = 0;
   int unsigned n_writes = 0;
   int unsigned n_ok = 0, n_bad_pct = 0, n_range = 0, n_zero_duty = 0, n_sat_duty = 0;
   int unsigned planned_items = 0;
   int unsigned stall_cycles = 0;

   // Scratch variables for the driver and the monitor.
   int unsigned gap_left = 0;
   bit          no_idle = 0;
   logic        start_next, csr_next;
   pwm_timing_type predicted, oldest;

   // Predicts the result for one percent from the bench's register copy. All
   // intermediate values are 64 bits wide, which holds every product here.
   function automatic pwm_timing_type calc_timing(logic [6:0] percent);
      logic [63:0] full_count, fit_limit, cycles, scaled, prescale, period_cnt;
      logic [63:0] duty_ns, duty_clocks, duty_cnt;
      int unsigned code;
      bit          fits;
      pwm_timing_type r;
      full_count = (64'd1 << PERIOD_BITS_DEF) - 64'd1;
      fit_limit = full_count * PRESCALE_LIMIT;
      fits = 1'b0;
      r.div_code = '0;
      r.prescale_code = '0;
      r.period_code = '0;
      r.duty_code = '0;
      r.duty_zero = 1'b0;
      r.status = STATUS_OK;
      if (percent > PCT_FULL) begin
         r.status = STATUS_BAD_PCT;
         return r;
      end
      cycles = (model_clk_hz * model_period_ns) / 64'(NS_PER_SEC);
      // Use the smallest divider code that brings the scaled count in reach.
      for (code = 0; code <= MAX_DIV_CODE_DEF; code++) begin
         scaled = cycles >> (code + 1);
         if (scaled <= fit_limit) begin
            fits = 1'b1;
            break;
         end
      end
      if (!fits) begin
         code = MAX_DIV_CODE_DEF;
         scaled = cycles >> (code + 1);
         r.status = STATUS_RANGE;
      end
      prescale = scaled / full_count + ((scaled % full_count) != 0 ? 64'd1 : 64'd0);
      if (prescale > PRESCALE_LIMIT) prescale = PRESCALE_LIMIT;
      if (prescale == 0) begin
         // The period is under one divided clock.
         prescale = 64'd1;
         r.status = STATUS_RANGE;
         period_cnt = 64'd0;
      end else begin
         period_cnt = scaled / prescale;
         period_cnt = (period_cnt == 0) ? 64'd0 : period_cnt - 64'd1;
         if (period_cnt > full_count) period_cnt = full_count;
      end
      duty_ns = (model_period_ns * 64'(percent)) / 64'(PCT_DIVISOR);
      duty_clocks = (model_clk_hz * duty_ns) / 64'(NS_PER_SEC);
      duty_cnt = (duty_clocks >> (code + 1)) / prescale;
      r.div_code = code[2:0];
      r.prescale_code = 8'(prescale - 64'd1);
      r.period_code = period_cnt[15:0];
      r.duty_code = (duty_cnt > 64'(FIELD16_MAX)) ? FIELD16_MAX : duty_cnt[15:0];
      r.duty_zero = (duty_cnt == 0);
      return r;
   endfunction

   // Gap before the next step. Most gaps are short and a few are long enough
   // to outlast a whole item, so the next request lands in every part of the
   // block's work. While no_idle is set, there are no gaps at all.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 4);
      return $urandom_range(20, 700);
   endfunction

   // Picks a value whose bit length is random, so that magnitudes spread
   // evenly from tiny to full scale. The top bit of the chosen length is set.
   function automatic logic [31:0] spread_value();
      int unsigned bits;
      logic [31:0] mask;
      bits = $urandom_range(1, 32);
      mask = (bits == 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
      return ($urandom & mask) | (32'd1 << (bits - 1));
   endfunction

   task automatic add_item(logic [6:0] percent);
      plan_step_type s;
      s.kind = STEP_ITEM;
      s.percent = percent;
      s.index = '0;
      s.data = '0;
      request_plan.push_back(s);
      planned_items++;
   endtask

   task automatic add_write(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
      plan_step_type s;
      s.kind = STEP_WRITE;
      s.percent = '0;
      s.index = index;
      s.data = data;
      request_plan.push_back(s);
   endtask

   task automatic add_drain();
      plan_step_type s;
      s.kind = STEP_DRAIN;
      s.percent = '0;
      s.index = '0;
      s.data = '0;
      request_plan.push_back(s);
   endtask

   // Prints one line for each wrong field and counts it.
   task automatic report_mismatch(string field, longint unsigned got,
                                  longint unsigned want);
      $display("ERROR at result %0d: %s is %0d, predicted %0d",
               n_results, field, got, want);
      n_errors++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Driver. When an item or a write is taken at an edge, the driver records
   // it, then picks the next step from the plan. Each control signal gets one
   // nonblocking assignment per edge, at the end. So a start that stays high
   // for back-to-back items is never lowered and raised in the same step.
   // Register writes and explicit drain steps wait until every result
   // already issued has come back. Each item gives exactly one result, so
   // the block is idle at that point.
   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         start_next = req_start;
         csr_next = csr_valid;
         if (req_start && !busy) begin
            predicted = calc_timing(req_percent);
            expected_timing.push_back(predicted);
            n_issued++;
            case (predicted.status)
               STATUS_OK:      n_ok++;
               STATUS_BAD_PCT: n_bad_pct++;
               default:        n_range++;
            endcase
            if (predicted.status != STATUS_BAD_PCT && predicted.duty_zero) n_zero_duty++;
            if (predicted.duty_code == FIELD16_MAX) n_sat_duty++;
            start_next = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CLK_HZ) model_clk_hz = 64'(csr_wdata);
            else model_period_ns = 64'(csr_wdata);
            n_writes++;
            csr_next = 1'b0;
         end
         if (!start_next && !csr_next) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (request_plan.size() != 0) begin
               case (request_plan[0].kind)
                  STEP_ITEM: begin
                     req_percent <= request_plan[0].percent;
                     start_next = 1'b1;
                     void'(request_plan.pop_front());
                     gap_left = pick_gap();
                  end
                  STEP_WRITE: begin
                     if (n_results == n_issued) begin
                        csr_index <= request_plan[0].index;
                        csr_wdata <= request_plan[0].data;
                        csr_next = 1'b1;
                        void'(request_plan.pop_front());
                        gap_left = pick_gap();
                     end
                  end
                  default: begin
                     // Hold off until everything issued has come back, then
                     // switch between gapped and gap-free traffic.
                     if (n_results == n_issued) begin
                        void'(request_plan.pop_front());
                        no_idle = ($urandom_range(0, 3) == 0);
                        gap_left = pick_gap();
                     end
                  end
               endcase
            end
         end
         req_start <= start_next;
         csr_valid <= csr_next;
      end
   end

   // Monitor. A result is valid for exactly one cycle and is taken at the
   // edge that ends it. Each field is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_results <= n_results + 1;
         if (expected_timing.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            oldest = expected_timing.pop_front();
            if (rsp_div_code !== oldest.div_code)
               report_mismatch("div_code", rsp_div_code, oldest.div_code);
            if (rsp_prescale_code !== oldest.prescale_code)
               report_mismatch("prescale_code", rsp_prescale_code, oldest.prescale_code);
            if (rsp_period_code !== oldest.period_code)
               report_mismatch("period_code", rsp_period_code, oldest.period_code);
            if (rsp_duty_code !== oldest.duty_code)
               report_mismatch("duty_code", rsp_duty_code, oldest.duty_code);
            if (rsp_duty_zero !== oldest.duty_zero)
               report_mismatch("duty_zero", rsp_duty_zero, oldest.duty_zero);
            if (rsp_status !== oldest.status)
               report_mismatch("status", rsp_status, oldest.status);
         end
      end
   end

   // Watchdog: ends the run if nothing is taken or returned for too long.
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned phase_items;
      int unsigned roll;
      reset = 1'b1;

      // Directed part, starting with the reset settings (200 MHz, 50 us).
      // This covers percent at both ends, the first rejected value, and all
      // bits of the percent field high and low.
      add_item(7'd0);
      add_item(7'd100);
      add_item(7'd101);
      add_item(7'd127);
      add_item(7'd50);
      add_item(7'd1);
      add_item(7'd99);
      // Both registers at full scale: the period is too long for any
      // divider, the prescale clamps, and the duty count saturates.
      add_write(CSR_CLK_HZ, 32'hffff_ffff);
      add_write(CSR_PERIOD, 32'hffff_ffff);
      add_item(7'd100);
      add_item(7'd37);
      add_item(7'd0);
      // A one hertz clock with a 1 ns period gives zero cycles, which is
      // the zero prescale case.
      add_write(CSR_CLK_HZ, 32'd1);
      add_write(CSR_PERIOD, 32'd1);
      add_item(7'd100);
      add_item(7'd0);
      // A zero period.
      add_write(CSR_CLK_HZ, 32'd200_000_000);
      add_write(CSR_PERIOD, 32'd0);
      add_item(7'd64);
      // At 1 GHz the cycle count equals the period. Four seconds need the
      // largest divider code and still fit.
      add_write(CSR_CLK_HZ, 32'd1_000_000_000);
      add_write(CSR_PERIOD, 32'd4_000_000_000);
      add_item(7'd100);
      add_item(7'd75);
      // A 2 ns period, right at the edge of zero prescale.
      add_write(CSR_PERIOD, 32'd2);
      add_item(7'd100);
      // A scaled count exactly at the fit limit, then just past it.
      add_write(CSR_PERIOD, 32'd33_553_920);
      add_item(7'd100);
      add_write(CSR_PERIOD, 32'd33_553_922);
      add_item(7'd100);
      // A slow clock with the longest period.
      add_write(CSR_CLK_HZ, 32'd1);
      add_write(CSR_PERIOD, 32'hffff_ffff);
      add_item(7'd100);

      // Random part. Each phase changes one or both registers. Most values
      // have a random bit length so that every divider code is reached, and
      // a few take the extreme values.
      while (planned_items < ITEM_TARGET) begin
         roll = $urandom_range(0, 9);
         if (roll != 0) begin
            roll = $urandom_range(0, 15);
            add_write(CSR_CLK_HZ, (roll == 0) ? 32'hffff_ffff :
                                  (roll == 1) ? 32'd1 : spread_value());
         end
         if (roll == 0 || $urandom_range(0, 9) != 0) begin
            roll = $urandom_range(0, 15);
            add_write(CSR_PERIOD, (roll == 0) ? 32'hffff_ffff :
                                  (roll == 1) ? 32'd0 : spread_value());
         end
         phase_items = $urandom_range(20, 90);
         repeat (phase_items) begin
            if ($urandom_range(0, 99) < 86) add_item(7'($urandom_range(0, 100)));
            else add_item(7'($urandom_range(101, 127)));
            if ($urandom_range(0, 99) < 3) add_drain();
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (request_plan.size() != 0 || req_start || csr_valid || n_results < n_issued)
         @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (expected_timing.size() != 0) begin
         $display("ERROR: %0d predicted results never arrived", expected_timing.size());
         n_errors++;
      end
      $display("Run covered %0d items: %0d ok, %0d rejected percent, %0d out of range.",
               n_issued, n_ok, n_bad_pct, n_range);
      $display("It made %0d register writes; %0d results had zero duty, %0d saturated duty.",
               n_writes, n_zero_duty, n_sat_duty);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
